FILE: src/pae_pkg.sv
// ----------------------------------------------------------------------------
// pae_pkg: shared types and constants for the PWM encoder unwrap block
// Field widths, opcodes, register indexes and the divider status bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package pae_pkg;

  localparam int PERIOD_W   = 24;
  localparam int POS_W      = 32;
  localparam int THR_W      = 13;
  localparam int DUTYV_W    = 13;
  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 80;
  localparam int CFG_IDX_W  = 8;

  localparam logic OP_CAPTURE = 1'b0;
  localparam logic OP_SET     = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_STARTUP_EN  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STARTUP_THR = 8'd1;

  localparam logic [THR_W-1:0] THR_RESET = 13'd2048;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage : pae_pkg

`default_nettype wire

FILE: src/pae_divider.sv
// ----------------------------------------------------------------------------
// pae_divider: iterative restoring divider
// One quotient bit per cycle, MSB first; quotient must fit in QUO_W bits.
// ----------------------------------------------------------------------------
`default_nettype none

module pae_divider
  import pae_pkg::*;
#(
  parameter int DEN_W = 24,
  parameter int QUO_W = 13
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  input  wire logic [DEN_W+QUO_W-1:0] num,
  input  wire logic [DEN_W-1:0]       den,
  output logic      [QUO_W-1:0]       quo,
  output div_stat_t                   stat
);

  localparam int CW    = DEN_W + QUO_W;
  localparam int CNT_W = $clog2(QUO_W);

  logic [CW-1:0]    rem_r;
  logic [CW-1:0]    dsr_r;
  logic [QUO_W-1:0] quo_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic             fits;

  assign fits = (rem_r >= dsr_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(QUO_W - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num;
      dsr_r <= CW'(den) << (QUO_W - 1);
      quo_r <= '0;
    end else if (busy_r) begin
      if (fits) begin
        rem_r <= rem_r - dsr_r;
      end
      quo_r <= {quo_r[QUO_W-2:0], fits};
      dsr_r <= dsr_r >> 1;
    end
  end

  assign quo       = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule : pae_divider

`default_nettype wire

FILE: src/pwm_absolute_encoder_unwrap_unit.sv
// Capture item: states S_MUL, S_START, S_WAIT, S_TURN, S_RAW and S_DONE from accept to result,
// DUTY_W = bits of RESOLUTION+1; the divider takes one cycle per quotient bit.
// Set-position and zero-period items go from accept straight to S_DONE, skipping the divider.
// One item in flight; the next item is accepted once the result is registered and the
// state is back in S_IDLE. A new item is taken while the last result waits at out_.
// Synchronous active-low reset clears state; config to startup off, threshold 2048.
// ----------------------------------------------------------------------------
// pwm_absolute_encoder_unwrap_unit: multi-turn unwrap of a PWM absolute encoder
// Duty from capture by iterative division, turn counting, position offset.
// ----------------------------------------------------------------------------
`default_nettype none

module pwm_absolute_encoder_unwrap_unit
  import pae_pkg::*;
#(
  parameter int RESOLUTION = 4096
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // config write channel
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [THR_W-1:0]      cfg_data,
  // input items
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // [23:0] pwm_period, [47:24] pwm_width, [79:48] new_position
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // [0] op
  input  wire logic                  in_tuser,
  // result items
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // [31:0] position, [63:32] turn_count, [76:64] duty_value, [79:77] zero
  output logic [OUT_DATA_W-1:0]      out_tdata,
  // [0] sample_used
  output logic                       out_tuser
);

  localparam int DUTY_W = $clog2(RESOLUTION + 1);
  localparam int PROD_W = DUTY_W + PERIOD_W;
  localparam int LIM_W  = DUTY_W + 3;
  localparam int CMP_W  = (DUTY_W > THR_W) ? DUTY_W : THR_W;

  localparam logic [PROD_W-1:0] RES_P  = PROD_W'(RESOLUTION);
  localparam logic [POS_W-1:0]  RES_32 = POS_W'(RESOLUTION);
  localparam logic [LIM_W-1:0]  LIM_LO = LIM_W'(RESOLUTION);
  localparam logic [LIM_W-1:0]  LIM_HI = LIM_W'(4 * RESOLUTION);

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_START, S_WAIT, S_TURN, S_RAW, S_DONE
  } state_t;

  state_t state_r, state_nxt;

  logic                  startup_en_r;
  logic [THR_W-1:0]      startup_thr_r;

  logic [DUTY_W-1:0]     last_duty_r, last_duty_nxt;
  logic [POS_W-1:0]      turns_r, turns_nxt;
  logic [POS_W-1:0]      raw_r, raw_nxt;
  logic [POS_W-1:0]      offset_r, offset_nxt;
  logic                  used_r, used_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic                  out_user_r, out_user_nxt;

  logic [PERIOD_W-1:0]   period_r;
  logic [PERIOD_W-1:0]   width_r;
  logic [PROD_W-1:0]     num_r;

  logic                  in_acc;
  logic [PERIOD_W-1:0]   in_period;
  logic [PERIOD_W-1:0]   in_width;
  logic [POS_W-1:0]      in_newpos;
  logic [PERIOD_W-1:0]   width_clamp;

  logic                  div_start;
  logic [DUTY_W-1:0]     div_quo;
  div_stat_t             div_stat;

  logic [LIM_W-1:0]      last5;
  logic [LIM_W-1:0]      duty5;

  assign in_period = in_tdata[23:0];
  assign in_width  = in_tdata[47:24];
  assign in_newpos = in_tdata[79:48];

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid & in_tready;
  assign cfg_ready = 1'b1;
  assign div_start = (state_r == S_START);

  assign width_clamp = (width_r > period_r) ? period_r : width_r;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      startup_en_r  <= 1'b0;
      startup_thr_r <= THR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_STARTUP_EN:  startup_en_r  <= cfg_data[0];
        CFG_STARTUP_THR: startup_thr_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- datapath
  always_ff @(posedge clk) begin
    if (in_acc) begin
      period_r <= in_period;
      width_r  <= in_width;
    end
    if (state_r == S_MUL) begin
      num_r <= RES_P * PROD_W'(width_clamp);
    end
  end

  pae_divider #(
    .DEN_W (PERIOD_W),
    .QUO_W (DUTY_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num_r),
    .den   (period_r),
    .quo   (div_quo),
    .stat  (div_stat)
  );

  assign last5 = (LIM_W'(last_duty_r) << 2) + LIM_W'(last_duty_r);
  assign duty5 = (LIM_W'(div_quo) << 2) + LIM_W'(div_quo);

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_nxt     = state_r;
    last_duty_nxt = last_duty_r;
    turns_nxt     = turns_r;
    raw_nxt       = raw_r;
    offset_nxt    = offset_r;
    used_nxt      = used_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          used_nxt = 1'b0;
          if (in_tuser == OP_SET) begin
            offset_nxt = in_newpos - raw_r;
            state_nxt  = S_DONE;
          end else if (in_period == '0) begin
            state_nxt = S_DONE;
          end else begin
            used_nxt  = 1'b1;
            state_nxt = S_MUL;
          end
        end
      end
      S_MUL:   state_nxt = S_START;
      S_START: state_nxt = S_WAIT;
      S_WAIT: begin
        if (div_stat.done) begin
          state_nxt = S_TURN;
        end
      end
      S_TURN: begin
        if (last_duty_r != '0) begin
          if (last5 > LIM_HI && duty5 < LIM_LO) begin
            turns_nxt = turns_r + 1'b1;
          end else if (last5 < LIM_LO && duty5 > LIM_HI) begin
            turns_nxt = turns_r - 1'b1;
          end
        end else if (startup_en_r && (CMP_W'(div_quo) > CMP_W'(startup_thr_r))) begin
          turns_nxt = '1;
        end
        last_duty_nxt = div_quo;
        state_nxt     = S_RAW;
      end
      S_RAW: begin
        raw_nxt   = POS_W'(turns_r * RES_32) + POS_W'(last_duty_r);
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_data_nxt        = '0;
          out_data_nxt[31:0]  = raw_r + offset_r;
          out_data_nxt[63:32] = turns_r;
          out_data_nxt[76:64] = DUTYV_W'(last_duty_r);
          out_user_nxt        = used_r;
          out_valid_nxt       = 1'b1;
          state_nxt           = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      last_duty_r <= '0;
      turns_r     <= '0;
      raw_r       <= '0;
      offset_r    <= '0;
      used_r      <= 1'b0;
      out_valid_r <= 1'b0;
      out_data_r  <= '0;
      out_user_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      last_duty_r <= last_duty_nxt;
      turns_r     <= turns_nxt;
      raw_r       <= raw_nxt;
      offset_r    <= offset_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
      out_data_r  <= out_data_nxt;
      out_user_r  <= out_user_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

`ifndef SYNTH
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while previous item still in progress");

  a_quo_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> (32'(div_quo) <= 32'(RESOLUTION)))
    else $error("duty quotient above resolution");

  a_last_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RAW |-> (32'(last_duty_r) <= 32'(RESOLUTION)))
    else $error("stored duty above resolution");

  a_div_only_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.busy |-> state_r == S_WAIT)
    else $error("divider running outside the wait state");
`endif

endmodule : pwm_absolute_encoder_unwrap_unit

`default_nettype wire

FILE: test/pwm_absolute_encoder_unwrap_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwm_absolute_encoder_unwrap_unit_tb: self-checking bench for the encoder unwrap
// Directed turn-count boundaries, start-up checks and random rotation streams
// under several idle and stall mixes, scored against an in-bench predictor.
// ----------------------------------------------------------------------------
module pwm_absolute_encoder_unwrap_unit_tb;
  import pae_pkg::*;

  localparam int RES          = 4096;
  localparam int DRAIN_CYCLES = 32;
  localparam int HANG_LIMIT   = 4000;
  localparam int RAND_ITEMS   = 350;

  // {sample_used, pad, duty_value, turn_count, position} as seen on tuser/tdata
  typedef struct packed {
    logic        used;
    logic [2:0]  pad;
    logic [12:0] duty;
    logic [31:0] turns;
    logic [31:0] position;
  } reading_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [THR_W-1:0]      cfg_data;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;

  // predictor state
  logic [31:0]      enc_last_duty;
  logic [31:0]      enc_turns;
  logic [31:0]      enc_raw_pos;
  logic [31:0]      enc_pos_offset;
  logic             su_enable;
  logic [THR_W-1:0] su_threshold;

  reading_t pending_readings[$];
  int       mismatches;
  int       stuck_cycles;
  int       send_idle_pct;
  int       recv_stall_pct;

  pwm_absolute_encoder_unwrap_unit #(
    .RESOLUTION(RES)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic reading_t predict_reading(input logic op, input logic [23:0] period,
                                               input logic [23:0] width,
                                               input logic [31:0] new_pos);
    logic [63:0] duty;
    logic [63:0] w;
    logic [63:0] last;
    logic [63:0] res;
    reading_t    r;
    res    = 64'(RES);
    w      = 64'(width);
    last   = 64'(enc_last_duty);
    r.used = 1'b0;
    if (op == OP_SET) begin
      enc_pos_offset = new_pos - enc_raw_pos;
    end else if (period != 24'd0) begin
      if (w > 64'(period)) w = 64'(period);
      duty = (res * w) / 64'(period);
      if (enc_last_duty != 32'd0) begin
        if (5 * last > 4 * res && 5 * duty < res) begin
          enc_turns = enc_turns + 32'd1;
        end else if (5 * last < res && 5 * duty > 4 * res) begin
          enc_turns = enc_turns - 32'd1;
        end
      end else if (su_enable && duty > 64'(su_threshold)) begin
        enc_turns = '1;
      end
      enc_last_duty = duty[31:0];
      enc_raw_pos   = enc_turns * 32'(RES) + duty[31:0];
      r.used        = 1'b1;
    end
    r.position = enc_raw_pos + enc_pos_offset;
    r.turns    = enc_turns;
    r.duty     = enc_last_duty[12:0];
    r.pad      = 3'd0;
    return r;
  endfunction

  // scoreboard, predictor update and hang watchdog, all on the sampling edge
  always @(posedge clk) begin
    reading_t got;
    reading_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = {out_tuser, out_tdata};
        if (pending_readings.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected item: pos=%0d turns=%0d duty=%0d used=%0b",
                     $signed(got.position), $signed(got.turns), got.duty, got.used);
        end else begin
          want = pending_readings.pop_front();
          if (got.position !== want.position || got.turns !== want.turns ||
              got.duty !== want.duty || got.used !== want.used || got.pad !== want.pad) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("bad item: exp pos=%0d turns=%0d duty=%0d used=%0b pad=%0d",
                       $signed(want.position), $signed(want.turns), want.duty, want.used,
                       want.pad);
              $display("          got pos=%0d turns=%0d duty=%0d used=%0b pad=%0d",
                       $signed(got.position), $signed(got.turns), got.duty,
                       got.used, got.pad);
            end
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_STARTUP_EN) su_enable = cfg_data[0];
        else if (cfg_index == CFG_STARTUP_THR) su_threshold = cfg_data;
      end
      if (in_tvalid && in_tready)
        pending_readings.push_back(predict_reading(in_tuser, in_tdata[23:0], in_tdata[47:24],
                                                   in_tdata[79:48]));
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        stuck_cycles = 0;
      else
        stuck_cycles++;
      if (stuck_cycles >= HANG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n) out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // entered and left on a falling edge; tvalid is left high for back-to-back items
  task automatic send_item(input logic op, input logic [23:0] period,
                           input logic [23:0] width, input logic [31:0] new_pos);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {new_pos, width, period};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_readings.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [THR_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // period 4096 makes duty equal to width, so thresholds can be hit exactly
  task automatic test_directed_turns();
    send_item(OP_CAPTURE, 24'd0, 24'hFFFFFF, 32'hFFFFFFFF);  // ignored capture
    send_item(OP_CAPTURE, 24'd4096, 24'd3500, 32'd0);
    send_item(OP_CAPTURE, 24'd4096, 24'd100, 32'd0);         // wrap forward
    send_item(OP_CAPTURE, 24'd4096, 24'd3500, 32'd0);        // wrap backward
    send_item(OP_CAPTURE, 24'd4096, 24'd3277, 32'd0);
    send_item(OP_CAPTURE, 24'd4096, 24'd819, 32'd0);         // both thresholds just met
    send_item(OP_CAPTURE, 24'd4096, 24'd820, 32'd0);
    send_item(OP_CAPTURE, 24'd4096, 24'd3276, 32'd0);
    send_item(OP_CAPTURE, 24'd4096, 24'd819, 32'd0);         // last just below upper
    send_item(OP_CAPTURE, 24'd4096, 24'd3277, 32'd0);        // backward at boundary
    send_item(OP_CAPTURE, 24'd1000, 24'hFFFFFF, 32'd0);      // width clamped
    send_item(OP_CAPTURE, 24'hFFFFFF, 24'hFFFFFF, 32'd0);
    send_item(OP_CAPTURE, 24'd1, 24'd0, 32'd0);
    send_item(OP_CAPTURE, 24'hFFFFFF, 24'd1, 32'd0);         // truncates to zero
    send_item(OP_SET, 24'hFFFFFF, 24'hFFFFFF, 32'h80000000);
    send_item(OP_SET, 24'd0, 24'd0, 32'h7FFFFFFF);
    send_item(OP_CAPTURE, 24'd1, 24'd1, 32'd0);
    send_item(OP_CAPTURE, 24'd4096, 24'd4095, 32'd0);
    send_item(OP_SET, 24'd0, 24'd0, 32'd0);
    wait_idle();
  endtask

  task automatic test_startup_check();
    write_reg(CFG_STARTUP_EN, THR_W'(1));
    write_reg(CFG_STARTUP_THR, THR_RESET);
    send_item(OP_CAPTURE, 24'd4096, 24'd0, 32'd0);
    send_item(OP_CAPTURE, 24'd4096, 24'd2048, 32'd0);        // equal: no start-up move
    send_item(OP_CAPTURE, 24'd4096, 24'd0, 32'd0);
    send_item(OP_CAPTURE, 24'd4096, 24'd2049, 32'd0);
    wait_idle();
    write_reg(CFG_STARTUP_THR, THR_W'(0));
    send_item(OP_CAPTURE, 24'd4096, 24'd0, 32'd0);
    send_item(OP_CAPTURE, 24'd4096, 24'd1, 32'd0);
    wait_idle();
    write_reg(CFG_STARTUP_THR, THR_W'(RES));                 // at resolution: never fires
    send_item(OP_CAPTURE, 24'd4096, 24'd0, 32'd0);
    send_item(OP_CAPTURE, 24'd777, 24'd777, 32'd0);
    wait_idle();
    write_reg(CFG_STARTUP_THR, 13'h1FFF);
    write_reg(CFG_STARTUP_EN, THR_W'(0));
    send_item(OP_CAPTURE, 24'd4096, 24'd0, 32'd0);
    send_item(OP_CAPTURE, 24'd4096, 24'd4000, 32'd0);
    wait_idle();
  endtask

  // mostly a turning shaft with random steps and periods, plus sets and noise
  task automatic test_random_rotation(input int idle_pct, input int stall_pct,
                                      input logic en, input logic [THR_W-1:0] thr);
    int          angle;
    int          step;
    int unsigned pick;
    logic [23:0] period;
    logic [23:0] width;
    logic [63:0] w64;
    write_reg(CFG_STARTUP_EN, THR_W'(en));
    write_reg(CFG_STARTUP_THR, thr);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    angle = $urandom_range(RES - 1);
    repeat (RAND_ITEMS) begin
      pick = $urandom_range(99);
      if ($urandom_range(3) == 0) period = 24'($urandom_range(1, 24'hFFFFFF));
      else period = 24'($urandom_range(16, 5000));
      if (pick < 70) begin
        step = $urandom_range(1300);
        if ($urandom_range(1)) angle = (angle + step) % RES;
        else angle = (angle - step + RES) % RES;
        w64   = (64'(angle) * 64'(period)) / 64'(RES);
        width = w64[23:0];
        send_item(OP_CAPTURE, period, width, $urandom);
      end else if (pick < 78) begin
        send_item(OP_CAPTURE, period, 24'd0, $urandom);
      end else if (pick < 86) begin
        send_item(OP_SET, 24'($urandom), 24'($urandom), $urandom);
      end else if (pick < 92) begin
        send_item(OP_CAPTURE, 24'd0, 24'($urandom), $urandom);
      end else begin
        send_item(1'($urandom_range(1)), 24'($urandom), 24'($urandom), $urandom);
      end
      if ($urandom_range(199) == 0) begin
        in_tvalid <= 1'b0;
        while (pending_readings.size() != 0) @(negedge clk);
      end
    end
    wait_idle();
  endtask

  initial begin
    clk            = 1'b0;
    rst_n          = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tuser       = OP_CAPTURE;
    out_tready     = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    mismatches     = 0;
    stuck_cycles   = 0;
    enc_last_duty  = '0;
    enc_turns      = '0;
    enc_raw_pos    = '0;
    enc_pos_offset = '0;
    su_enable      = 1'b0;
    su_threshold   = THR_RESET;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_turns();
    test_startup_check();
    test_random_rotation(0, 0, 1'b0, THR_RESET);
    test_random_rotation(86, 0, 1'b1, THR_W'(0));
    test_random_rotation(0, 86, 1'b1, THR_W'(RES));
    test_random_rotation(23, 23, 1'b1, THR_W'($urandom_range(1, RES - 1)));

    if (mismatches == 0 && pending_readings.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
